FILE: hdl/gprmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gprmc_pkg
// Types, constants and the control store of the GPRMC sentence extractor.
// ----------------------------------------------------------------------------
package gprmc_pkg;

  localparam int unsigned PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [3:0] STATUS_SKIP = 4'd11;
  localparam logic [3:0] END_COMMA   = 4'd9;
  localparam logic [2:0] HDR_LAST    = 3'd5;

  typedef enum logic [2:0] {
    PH_HUNT        = 3'd0,
    PH_SKIP_STATUS = 3'd1,
    PH_STATUS      = 3'd2,
    PH_SKIP_ONE    = 3'd3,
    PH_FIELDS      = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_FETCH,
    OP_OTHER,
    OP_EMIT,
    OP_STATUS_END,
    OP_COUNT,
    OP_CHECK_V,
    OP_STORE,
    OP_RD,
    OP_DUMP_END
  } op_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_IN,
    COND_PH_STATUS,
    COND_PH_FIELDS,
    COND_IS_A,
    COND_COUNT9,
    COND_IDX_MORE
  } cond_t;

  typedef enum logic [1:0] {
    SRC_CONST,
    SRC_BYTE,
    SRC_REC
  } src_t;

  typedef enum logic [1:0] {
    LAST_NO,
    LAST_YES,
    LAST_IF_A
  } last_t;

  typedef struct packed {
    op_t        op;
    src_t       src;
    logic [7:0] data;
    last_t      last;
    cond_t      cond;
    pc_t        target;
  } ucode_t;

  // program labels
  localparam pc_t S_FETCH  = 5'd0;
  localparam pc_t S_STATUS = 5'd4;
  localparam pc_t S_FIELDS = 5'd9;
  localparam pc_t S_DUMP   = 5'd12;

  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = CH_DOLLAR;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4D;
      3'd5:    c = 8'h43;
      default: c = CH_DOLLAR;
    endcase
    return c;
  endfunction

  function automatic ucode_t ucw(input op_t op, input src_t src, input logic [7:0] data,
                                 input last_t last, input cond_t cond, input pc_t target);
    ucode_t w;
    w.op     = op;
    w.src    = src;
    w.data   = data;
    w.last   = last;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic ucode_t ucode(input pc_t pc);
    ucode_t w;
    unique case (pc)
      5'd0:    w = ucw(OP_FETCH, SRC_CONST, 8'h00, LAST_NO, COND_NO_IN, S_FETCH);
      5'd1:    w = ucw(OP_NOP, SRC_CONST, 8'h00, LAST_NO, COND_PH_STATUS, S_STATUS);
      5'd2:    w = ucw(OP_NOP, SRC_CONST, 8'h00, LAST_NO, COND_PH_FIELDS, S_FIELDS);
      5'd3:    w = ucw(OP_OTHER, SRC_CONST, 8'h00, LAST_NO, COND_ALWAYS, S_FETCH);
      5'd4:    w = ucw(OP_EMIT, SRC_CONST, CH_H, LAST_NO, COND_NEXT, S_FETCH);
      5'd5:    w = ucw(OP_EMIT, SRC_BYTE, 8'h00, LAST_NO, COND_NEXT, S_FETCH);
      5'd6:    w = ucw(OP_EMIT, SRC_CONST, CH_H, LAST_IF_A, COND_NEXT, S_FETCH);
      5'd7:    w = ucw(OP_STATUS_END, SRC_CONST, 8'h00, LAST_NO, COND_IS_A, S_FETCH);
      5'd8:    w = ucw(OP_EMIT, SRC_CONST, CH_V, LAST_YES, COND_ALWAYS, S_FETCH);
      5'd9:    w = ucw(OP_COUNT, SRC_CONST, 8'h00, LAST_NO, COND_NEXT, S_FETCH);
      5'd10:   w = ucw(OP_CHECK_V, SRC_CONST, 8'h00, LAST_NO, COND_COUNT9, S_DUMP);
      5'd11:   w = ucw(OP_STORE, SRC_CONST, 8'h00, LAST_NO, COND_ALWAYS, S_FETCH);
      5'd12:   w = ucw(OP_RD, SRC_CONST, 8'h00, LAST_NO, COND_NEXT, S_FETCH);
      5'd13:   w = ucw(OP_EMIT, SRC_REC, 8'h00, LAST_NO, COND_IDX_MORE, S_DUMP);
      5'd14:   w = ucw(OP_EMIT, SRC_CONST, CH_CR, LAST_NO, COND_NEXT, S_FETCH);
      5'd15:   w = ucw(OP_EMIT, SRC_CONST, CH_LF, LAST_NO, COND_NEXT, S_FETCH);
      5'd16:   w = ucw(OP_EMIT, SRC_CONST, CH_CR, LAST_YES, COND_NEXT, S_FETCH);
      5'd17:   w = ucw(OP_DUMP_END, SRC_CONST, 8'h00, LAST_NO, COND_ALWAYS, S_FETCH);
      default: w = ucw(OP_NOP, SRC_CONST, 8'h00, LAST_NO, COND_ALWAYS, S_FETCH);
    endcase
    return w;
  endfunction

endpackage

FILE: hdl/gprmc_sentence_extractor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gprmc_sentence_extractor_top
// Microcoded GPRMC sentence extractor with a byte record and a byte stream out.
// ----------------------------------------------------------------------------
// Bytes enter one per input transaction and leave one per output transaction
// through a registered output stage. A small sequencer steps through a control
// store, one control word per cycle unless an emitting word waits on an output
// stall. A header hunt or skip byte passes the fetch, both phase checks and the
// header step; a field byte that does not end the sentence passes the fetch, both
// phase checks, the comma count, the 'V' check and the store. A status byte emits
// 'H', itself and 'H', plus 'V' if not 'A'. The closing comma starts the record
// dump: one memory read and one emit per record byte. Every emitting step is
// stretched by any output stall. The record memory needs no clearing pass after
// reset: a valid bit per slot makes slots not written since reset read as zero.
module gprmc_sentence_extractor_top #(
  parameter int unsigned RECORD_BYTES = 38
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       last_of_run
);
  import gprmc_pkg::*;

  localparam int unsigned IDX_W = $clog2(RECORD_BYTES);
  localparam int unsigned WP_W  = $clog2(RECORD_BYTES + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RECORD_BYTES - 1);
  localparam logic [WP_W-1:0]  WP_FULL  = WP_W'(RECORD_BYTES);

  ucode_t cw;
  pc_t    pc, pc_next;

  logic [7:0]       cur_byte;
  phase_t           phase, phase_next;
  logic [2:0]       match_pos, match_pos_next;
  logic [3:0]       skip_left, skip_left_next;
  logic             fix_valid, fix_valid_next;
  logic [3:0]       comma_count, comma_count_next;
  logic [WP_W-1:0]  write_pos, write_pos_next;
  logic [IDX_W-1:0] rd_idx, rd_idx_next;

  logic [7:0]              record_mem [RECORD_BYTES];
  logic [RECORD_BYTES-1:0] slot_valid;
  logic [7:0]              rd_data;
  logic                    rd_ok;

  logic       slot_free, go, take_in, emit, cond_hit, is_a, store_en;
  logic [7:0] emit_byte;
  logic       emit_last;

  assign cw        = ucode(pc);
  assign slot_free = !out_valid || !out_stall;
  assign is_a      = (cur_byte == CH_A);

  // handshake and emit selection
  always_comb begin
    in_stall  = (cw.op != OP_FETCH);
    take_in   = (cw.op == OP_FETCH) && in_valid;
    emit      = (cw.op == OP_EMIT) && slot_free;
    go        = (cw.op != OP_EMIT) || slot_free;
    store_en  = (cw.op == OP_STORE) && (write_pos < WP_FULL)
                && !(comma_count == 4'd1 || comma_count == 4'd6 || comma_count == 4'd7);
    unique case (cw.src)
      SRC_BYTE: emit_byte = cur_byte;
      SRC_REC:  emit_byte = rd_ok ? rd_data : 8'h00;
      default:  emit_byte = cw.data;
    endcase
    unique case (cw.last)
      LAST_YES:  emit_last = 1'b1;
      LAST_IF_A: emit_last = is_a;
      default:   emit_last = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    unique case (cw.cond)
      COND_ALWAYS:    cond_hit = 1'b1;
      COND_NO_IN:     cond_hit = !in_valid;
      COND_PH_STATUS: cond_hit = (phase == PH_STATUS);
      COND_PH_FIELDS: cond_hit = (phase == PH_FIELDS);
      COND_IS_A:      cond_hit = is_a;
      COND_COUNT9:    cond_hit = (comma_count == END_COMMA);
      COND_IDX_MORE:  cond_hit = (rd_idx != IDX_LAST);
      default:        cond_hit = 1'b0;
    endcase
    if (!go) begin
      pc_next = pc;
    end else if (cond_hit) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  // datapath next values
  always_comb begin
    phase_next       = phase;
    match_pos_next   = match_pos;
    skip_left_next   = skip_left;
    fix_valid_next   = fix_valid;
    comma_count_next = comma_count;
    write_pos_next   = write_pos;
    rd_idx_next      = rd_idx;
    unique case (cw.op)
      OP_OTHER: begin
        unique case (phase)
          PH_SKIP_STATUS: begin
            if (skip_left <= 4'd1) begin
              skip_left_next = 4'd0;
              phase_next     = PH_STATUS;
            end else begin
              skip_left_next = skip_left - 4'd1;
            end
          end
          PH_SKIP_ONE: begin
            comma_count_next = 4'd0;
            write_pos_next   = '0;
            phase_next       = PH_FIELDS;
          end
          default: begin
            if (cur_byte == hdr_char(match_pos)) begin
              if (match_pos == HDR_LAST) begin
                match_pos_next = 3'd0;
                if (fix_valid) begin
                  phase_next = PH_SKIP_ONE;
                end else begin
                  skip_left_next = STATUS_SKIP;
                  phase_next     = PH_SKIP_STATUS;
                end
              end else begin
                match_pos_next = match_pos + 3'd1;
              end
            end else begin
              match_pos_next = 3'd0;
            end
          end
        endcase
      end
      OP_STATUS_END: begin
        if (is_a) begin
          fix_valid_next = 1'b1;
        end
        phase_next     = PH_HUNT;
        match_pos_next = 3'd0;
      end
      OP_COUNT: begin
        if (cur_byte == CH_COMMA) begin
          comma_count_next = comma_count + 4'd1;
        end
      end
      OP_CHECK_V: begin
        if (comma_count == 4'd1 && cur_byte == CH_V) begin
          fix_valid_next = 1'b0;
        end
      end
      OP_STORE: begin
        if (store_en) begin
          write_pos_next = write_pos + 1'b1;
        end
      end
      OP_EMIT: begin
        if (emit && cw.src == SRC_REC) begin
          rd_idx_next = (rd_idx == IDX_LAST) ? '0 : rd_idx + 1'b1;
        end
      end
      OP_DUMP_END: begin
        comma_count_next = 4'd0;
        phase_next       = PH_HUNT;
        match_pos_next   = 3'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= S_FETCH;
      phase       <= PH_HUNT;
      match_pos   <= 3'd0;
      skip_left   <= 4'd0;
      fix_valid   <= 1'b0;
      comma_count <= 4'd0;
      write_pos   <= '0;
      rd_idx      <= '0;
      slot_valid  <= '0;
      out_valid   <= 1'b0;
    end else begin
      pc          <= pc_next;
      phase       <= phase_next;
      match_pos   <= match_pos_next;
      skip_left   <= skip_left_next;
      fix_valid   <= fix_valid_next;
      comma_count <= comma_count_next;
      write_pos   <= write_pos_next;
      rd_idx      <= rd_idx_next;
      if (store_en) begin
        slot_valid[write_pos[IDX_W-1:0]] <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take_in) begin
      cur_byte <= rx_byte;
    end
    if (emit) begin
      tx_byte     <= emit_byte;
      last_of_run <= emit_last;
    end
  end

  // record memory
  always_ff @(posedge clk) begin
    if (store_en) begin
      record_mem[write_pos[IDX_W-1:0]] <= cur_byte;
    end
    if (cw.op == OP_RD) begin
      rd_data <= record_mem[rd_idx];
      rd_ok   <= slot_valid[rd_idx];
    end
  end

endmodule
